FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL. Each macro names the clock and reset
// of the module that uses it, so both must be in scope as i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NEVER(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/ctb_pkg.sv
package ctb_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int DUR_W   = 27;
    localparam int MASK_W  = 16;
    localparam int ELAP_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int EVENT_W = 3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [SLOTS-1:0] t_vec;
    typedef logic [DUR_W-1:0] t_dur;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_PAUSE = 2'd2,
        KIND_CONT  = 2'd3
    } t_kind;

    typedef enum logic [EVENT_W-1:0] {
        EV_ADDED     = 3'd0,
        EV_FULL      = 3'd1,
        EV_EXPIRED   = 3'd2,
        EV_TICK_DONE = 3'd3,
        EV_SEL_DONE  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Accepted item handed to the engine.
    typedef struct packed {
        logic                go;
        t_kind               kind;
        t_dur                duration_ms;
        logic [MASK_W-1:0]   select_mask;
        logic [ELAP_W-1:0]   elapsed_ms;
    } t_cmd;

    // Engine results, stable from done until the next command.
    typedef struct packed {
        logic done;
        logic add_ok;
        t_idx add_slot;
        t_vec expired;
        logic nearest_valid;
        t_idx nearest_slot;
        t_dur nearest_rem;
    } t_stat;

    typedef struct packed {
        logic we;
        t_idx waddr;
        t_dur wdata;
        t_idx raddr;
    } t_mem_req;

    // Index of the lowest set bit; zero when none is set.
    function automatic t_idx lowest_set(t_vec v);
        t_idx r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = t_idx'(i);
            end
        end
        return r;
    endfunction

    // Slot index as carried in the result fields, modulo sixteen.
    function automatic logic [SLOT_W-1:0] to_slot(t_idx idx);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

endpackage

FILE: sv/ctb_if.sv
interface ctb_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [ctb_pkg::DUR_W-1:0]  duration_ms;
    logic [ctb_pkg::MASK_W-1:0] select_mask;
    logic [ctb_pkg::ELAP_W-1:0] elapsed_ms;

    modport source (output valid, kind, duration_ms, select_mask, elapsed_ms,
                    input ready);
    modport sink   (input valid, kind, duration_ms, select_mask, elapsed_ms,
                    output ready);
endinterface

interface ctb_out_if;
    logic                        valid;
    logic                        ready;
    logic [ctb_pkg::EVENT_W-1:0] event_res;
    logic [ctb_pkg::SLOT_W-1:0]  slot;
    logic                        nearest_valid;
    logic [ctb_pkg::SLOT_W-1:0]  nearest_slot;
    logic [ctb_pkg::DUR_W-1:0]   nearest_remaining;
    logic                        last;

    modport source (output valid, event_res, slot, nearest_valid, nearest_slot,
                    nearest_remaining, last, input ready);
    modport sink   (input valid, event_res, slot, nearest_valid, nearest_slot,
                    nearest_remaining, last, output ready);
endinterface

FILE: sv/ctb_mem.sv
module ctb_mem (
    input  logic              i_clk,
    input  ctb_pkg::t_mem_req i_req,
    output ctb_pkg::t_dur     o_rdata
);
    import ctb_pkg::*;

    t_dur r_mem [SLOTS];
    t_dur r_rdata;

    // Remaining time of each slot; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ctb_engine.sv
module ctb_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctb_pkg::t_cmd     i_cmd,
    output ctb_pkg::t_stat    o_stat,
    output ctb_pkg::t_mem_req o_mem_req,
    input  ctb_pkg::t_dur     i_rdata
);
    import ctb_pkg::*;

    t_vec             r_act;
    t_vec             r_pau;
    t_vec             r_exp;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_rd_run;
    logic             r_pv;
    t_idx             r_p_idx;
    logic             r_done;
    logic             r_is_tick;
    t_dur             r_elapsed;
    logic             r_nv;
    t_idx             r_ns;
    t_dur             r_nr;
    logic             r_add_ok;
    t_idx             r_add_slot;

    t_vec                     free_vec;
    logic                     free_any;
    t_idx                     free_idx;
    logic [SLOTS+MASK_W-1:0]  mask_ext;
    t_idx                     rd_idx;
    logic                     p_act;
    logic                     p_pau;
    logic                     p_zero;
    logic                     p_over;
    logic                     p_count;
    logic                     p_expire;
    t_dur                     p_new;
    logic                     p_better;
    logic                     add_we;

    assign free_vec = ~r_act;
    assign free_any = |free_vec;
    assign free_idx = lowest_set(free_vec);
    assign mask_ext = {{SLOTS{1'b0}}, i_cmd.select_mask};
    assign rd_idx   = r_rd_idx[IDX_W-1:0];
    assign add_we   = i_cmd.go && (i_cmd.kind == KIND_ADD) && free_any;

    // One slot leaves the memory each cycle; its fate is decided here.
    always_comb begin
        p_act    = r_act[r_p_idx];
        p_pau    = r_pau[r_p_idx];
        p_zero   = (i_rdata == '0);
        p_over   = r_elapsed > i_rdata;
        p_count  = r_is_tick && p_act && !p_zero && !p_pau && !p_over;
        p_expire = r_is_tick && p_act && (p_zero || (!p_pau && p_over));
        p_new    = p_count ? (i_rdata - r_elapsed) : i_rdata;
        p_better = p_act && !p_expire && (!r_nv || (p_new < r_nr));
    end

    always_comb begin
        o_mem_req.raddr = rd_idx;
        if (add_we) begin
            o_mem_req.we    = 1'b1;
            o_mem_req.waddr = free_idx;
            o_mem_req.wdata = i_cmd.duration_ms;
        end else begin
            o_mem_req.we    = r_pv && p_count;
            o_mem_req.waddr = r_p_idx;
            o_mem_req.wdata = p_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= '0;
            r_pau    <= '0;
            r_rd_run <= 1'b0;
            r_rd_idx <= '0;
            r_pv     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_pv && (r_p_idx == t_idx'(SLOTS - 1));
            r_pv   <= r_rd_run;
            if (i_cmd.go) begin
                r_rd_run <= 1'b1;
                r_rd_idx <= '0;
                if (add_we) begin
                    r_act[free_idx] <= 1'b1;
                    r_pau[free_idx] <= 1'b0;
                end
                if (i_cmd.kind == KIND_PAUSE || i_cmd.kind == KIND_CONT) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (mask_ext[i] && r_act[i]) begin
                            r_pau[i] <= (i_cmd.kind == KIND_PAUSE);
                        end
                    end
                end
            end else if (r_rd_run) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
                if (r_rd_idx == CNT_W'(SLOTS - 1)) begin
                    r_rd_run <= 1'b0;
                end
            end
            if (r_pv && p_expire) begin
                r_act[r_p_idx] <= 1'b0;
                r_pau[r_p_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_run) begin
            r_p_idx <= rd_idx;
        end
        if (i_cmd.go) begin
            r_is_tick  <= (i_cmd.kind == KIND_TICK);
            r_elapsed  <= DUR_W'(i_cmd.elapsed_ms);
            r_exp      <= '0;
            r_nv       <= 1'b0;
            r_ns       <= '0;
            r_nr       <= '0;
            r_add_ok   <= free_any;
            r_add_slot <= free_idx;
        end else if (r_pv) begin
            if (p_expire) begin
                r_exp[r_p_idx] <= 1'b1;
            end
            if (p_better) begin
                r_nv <= 1'b1;
                r_ns <= r_p_idx;
                r_nr <= p_new;
            end
        end
    end

    always_comb begin
        o_stat.done          = r_done;
        o_stat.add_ok        = r_add_ok;
        o_stat.add_slot      = r_add_slot;
        o_stat.expired       = r_exp;
        o_stat.nearest_valid = r_nv;
        o_stat.nearest_slot  = r_ns;
        o_stat.nearest_rem   = r_nr;
    end

endmodule

FILE: sv/countdown_timer_bank.sv
// Bank of millisecond countdown timers held in one slot memory.
// Input channel i_in carries one item: an add (load a duration into the
// lowest free slot), a tick (milliseconds elapsed), or a pause or continue
// of the slots chosen in a mask. Output channel o_out returns the results
// of that item: for a tick, one expired result per slot that ran out, in
// slot order, then a closing result; for every other kind a single result.
// Every result carries the nearest timer as it stands after the item, and
// the closing result has last set.
// The engine walks all slots through the memory, one slot a cycle, with
// registered read data; once the walk is done the results follow one a
// cycle while the receiver takes them.
// Only one item is in flight: i_in.ready is high while the bank is idle.
// A stalled receiver simply holds the current result; nothing is lost.
// Synchronous reset marks every slot free and unpaused and drops any item
// in flight; the memory itself is not cleared, as the data of free slots is ignored.
module countdown_timer_bank (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctb_in_if.sink    i_in,
    ctb_out_if.source o_out
);
    import ctb_pkg::*;

    `include "assert_macros.svh"

    t_state   r_state;
    t_state   n_state;
    t_kind    r_kind;
    t_vec     r_exp_left;

    t_cmd     cmd;
    t_stat    stat;
    t_mem_req mem_req;
    t_dur     mem_rdata;
    logic     in_acc;
    logic     out_acc;
    logic     exp_any;
    t_event   ev;
    logic [SLOT_W-1:0] ev_slot;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign exp_any = |r_exp_left;

    always_comb begin
        cmd.go          = in_acc;
        cmd.kind        = t_kind'(i_in.kind);
        cmd.duration_ms = i_in.duration_ms;
        cmd.select_mask = i_in.select_mask;
        cmd.elapsed_ms  = i_in.elapsed_ms;
    end

    ctb_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

    ctb_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Sequencer: idle, walk the slots, then hand out the results.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc && !exp_any) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_exp_left <= '0;
        end else begin
            r_state <= n_state;
            if (stat.done) begin
                r_exp_left <= stat.expired;
            end else if (out_acc && exp_any) begin
                // Drop the expiry just delivered, lowest slot first.
                r_exp_left <= r_exp_left & (r_exp_left - t_vec'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= t_kind'(i_in.kind);
        end
    end

    // Result selection: pending expiries first, then the closing result.
    always_comb begin
        ev      = EV_SEL_DONE;
        ev_slot = '0;
        if (exp_any) begin
            ev      = EV_EXPIRED;
            ev_slot = to_slot(lowest_set(r_exp_left));
        end else begin
            unique case (r_kind)
                KIND_ADD: begin
                    ev      = stat.add_ok ? EV_ADDED : EV_FULL;
                    ev_slot = stat.add_ok ? to_slot(stat.add_slot) : '0;
                end
                KIND_TICK:  ev = EV_TICK_DONE;
                KIND_PAUSE: ev = EV_SEL_DONE;
                KIND_CONT:  ev = EV_SEL_DONE;
                default:    ev = EV_SEL_DONE;
            endcase
        end
    end

    always_comb begin
        i_in.ready              = (r_state == ST_IDLE);
        o_out.valid             = (r_state == ST_EMIT);
        o_out.event_res         = ev;
        o_out.slot              = ev_slot;
        o_out.nearest_valid     = stat.nearest_valid;
        o_out.nearest_slot      = stat.nearest_valid ? to_slot(stat.nearest_slot) : '0;
        o_out.nearest_remaining = stat.nearest_valid ? stat.nearest_rem : '0;
        o_out.last              = !exp_any;
    end

    // The bank never takes an item while a result is on offer.
    `ASSERT_NEVER(a_no_overlap, i_in.ready && o_out.valid, "item taken during results")
    // The slot walk only finishes while the sequencer waits for it.
    `ASSERT_IMPLY(a_done_in_scan, stat.done, r_state == ST_SCAN, "walk ended outside scan")
    // An expiry result is never the closing one.
    `ASSERT_IMPLY(a_exp_not_last, o_out.valid && o_out.event_res == EV_EXPIRED,
        !o_out.last, "expiry marked last")
    // An accepted item blocks the input until its results are out.
    `ASSERT_NEXT(a_busy_after_accept, in_acc, !i_in.ready, "input open after accept")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the countdown timer bank. The input side walks a
// short table of hand-picked items and then a long stretch of random ones.
// Every accepted item is fed to a local model of the slot bank, which queues
// the results it should cause. The output side pops that queue and compares
// each result field by field.
module tb;

    import ctb_pkg::*;

    // One item on the input channel.
    typedef struct packed {
        t_kind             kind;
        t_dur              dur;
        logic [MASK_W-1:0] mask;
        logic [ELAP_W-1:0] elapsed;
    } t_timer_cmd;

    // One result on the output channel.
    typedef struct packed {
        t_event            ev;
        logic [SLOT_W-1:0] slot;
        logic              nv;
        logic [SLOT_W-1:0] ns;
        t_dur              nr;
        logic              last;
    } t_timer_result;

    // A row of the directed table. Where the outcome is obvious it is typed
    // in by hand and replaces what the model would queue.
    typedef struct {
        t_timer_cmd    cmd;
        int            reps;
        bit            typed;
        t_timer_result want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    ctb_in_if  in_ch ();
    ctb_out_if out_ch ();

    countdown_timer_bank uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Local copy of the slot bank.
    t_dur timer_left [SLOTS];
    t_vec timer_on;
    t_vec timer_held;

    t_timer_result awaited_results [$];
    t_plan_row     plan [$];
    int            n_errors;
    int            hold_left;
    bit            steady;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Guard against a hung handshake.
    initial begin
        #15_000_000;
        $display("tb failed");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Active slot with the least time left, lowest index winning a tie.
    task automatic find_nearest(output logic nv, output logic [SLOT_W-1:0] ns,
                                output t_dur nr);
        nv = 1'b0;
        ns = '0;
        nr = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (timer_on[i] && (!nv || timer_left[i] < nr)) begin
                nv = 1'b1;
                ns = SLOT_W'(i);
                nr = timer_left[i];
            end
        end
    endtask

    // Applies one accepted item to the local bank and queues its results.
    task automatic apply_item(input t_timer_cmd c, input bit typed,
                              input t_timer_result typed_res);
        t_timer_result     res;
        t_vec              gone;
        int                free_idx;
        logic              nv;
        logic [SLOT_W-1:0] ns;
        t_dur              nr;
        gone = '0;
        free_idx = -1;
        res = '0;
        unique case (c.kind)
            KIND_ADD: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!timer_on[i]) begin
                        free_idx = i;
                    end
                end
                // A load always starts the slot running, unpaused.
                if (free_idx >= 0) begin
                    timer_on[free_idx]   = 1'b1;
                    timer_held[free_idx] = 1'b0;
                    timer_left[free_idx] = c.dur;
                    res.ev   = EV_ADDED;
                    res.slot = SLOT_W'(free_idx);
                end else begin
                    res.ev = EV_FULL;
                end
            end
            KIND_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (timer_on[i]) begin
                        // A slot already at zero goes even when paused.
                        if (timer_left[i] == '0) begin
                            gone[i] = 1'b1;
                        end else if (!timer_held[i]) begin
                            if (t_dur'(c.elapsed) > timer_left[i]) begin
                                gone[i] = 1'b1;
                            end else begin
                                timer_left[i] = timer_left[i] - t_dur'(c.elapsed);
                            end
                        end
                        if (gone[i]) begin
                            timer_on[i]   = 1'b0;
                            timer_held[i] = 1'b0;
                        end
                    end
                end
                res.ev = EV_TICK_DONE;
            end
            default: begin
                // Pause and continue only touch slots that are running.
                for (int i = 0; i < SLOTS && i < MASK_W; i++) begin
                    if (c.mask[i] && timer_on[i]) begin
                        timer_held[i] = (c.kind == KIND_PAUSE);
                    end
                end
                res.ev = EV_SEL_DONE;
            end
        endcase
        // Every result of the item carries the nearest timer as it stands
        // once the whole item has been applied.
        find_nearest(nv, ns, nr);
        res.nv = nv;
        res.ns = ns;
        res.nr = nr;
        if (typed) begin
            awaited_results.push_back(typed_res);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (gone[i]) begin
                    awaited_results.push_back('{EV_EXPIRED, SLOT_W'(i), nv, ns, nr, 1'b0});
                end
            end
            res.last = 1'b1;
            awaited_results.push_back(res);
        end
    endtask

    // Presents one item after an optional idle gap and returns at the edge
    // that accepts it, with valid still high.
    task automatic send_cmd(input t_timer_cmd c, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= c.kind;
        in_ch.duration_ms <= c.dur;
        in_ch.select_mask <= c.mask;
        in_ch.elapsed_ms  <= c.elapsed;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    // Holds the input side off until every queued result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (awaited_results.size() != 0);
    endtask

    function automatic void plan_row(t_kind k, t_dur dur, logic [MASK_W-1:0] mask,
                                     logic [ELAP_W-1:0] elapsed, int reps = 1,
                                     bit typed = 1'b0, t_event ev = EV_ADDED,
                                     logic [SLOT_W-1:0] slot = '0, logic nv = 1'b0,
                                     logic [SLOT_W-1:0] ns = '0, t_dur nr = '0);
        t_plan_row row;
        row.cmd   = '{k, dur, mask, elapsed};
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{ev, slot, nv, ns, nr, 1'b1};
        plan.push_back(row);
    endfunction

    function automatic void flag(string what, longint want, longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        n_errors++;
    endfunction

    // Output side: random back-pressure, switched off in steady stretches.
    initial begin
        out_ch.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) begin
                    hold_left = pick_gap();
                end
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // one still awaited.
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got event_res %0d slot %0d",
                         $time, out_ch.event_res, out_ch.slot);
                n_errors++;
            end else begin
                want = awaited_results.pop_front();
                if (out_ch.event_res !== want.ev) begin
                    flag("event_res", want.ev, out_ch.event_res);
                end
                if (out_ch.slot !== want.slot) begin
                    flag("slot", want.slot, out_ch.slot);
                end
                if (out_ch.nearest_valid !== want.nv) begin
                    flag("nearest_valid", want.nv, out_ch.nearest_valid);
                end
                if (out_ch.nearest_slot !== want.ns) begin
                    flag("nearest_slot", want.ns, out_ch.nearest_slot);
                end
                if (out_ch.nearest_remaining !== want.nr) begin
                    flag("nearest_remaining", want.nr, out_ch.nearest_remaining);
                end
                if (out_ch.last !== want.last) begin
                    flag("last", want.last, out_ch.last);
                end
            end
        end
    end

    initial begin
        t_timer_cmd c;
        int         r;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_ADD;
        in_ch.duration_ms = '0;
        in_ch.select_mask = '0;
        in_ch.elapsed_ms  = '0;
        i_rst_n           = 1'b0;
        n_errors          = 0;
        steady            = 1'b0;
        timer_on          = '0;
        timer_held        = '0;
        for (int i = 0; i < SLOTS; i++) begin
            timer_left[i] = '0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty bank: a tick and a pause touch nothing.
        plan_row(KIND_TICK, 0, 16'h0000, 0, 1, 1, EV_TICK_DONE, 0, 0, 0, 0);
        plan_row(KIND_PAUSE, 0, 16'hFFFF, 0, 1, 1, EV_SEL_DONE, 0, 0, 0, 0);
        // Fill every slot, starting with a zero duration, then one add too many.
        plan_row(KIND_ADD, 0, 16'h0000, 0, 1, 1, EV_ADDED, 0, 1, 0, 0);
        plan_row(KIND_ADD, 7, 16'h0000, 0, SLOTS - 1);
        plan_row(KIND_ADD, 9, 16'h0000, 0, 1, 1, EV_FULL, 0, 1, 0, 0);
        // A paused slot at zero still expires; the rest count down to one.
        plan_row(KIND_PAUSE, 0, 16'h0001, 0, 1, 1, EV_SEL_DONE, 0, 1, 0, 0);
        plan_row(KIND_TICK, 0, 16'h0000, 6);
        plan_row(KIND_ADD, 1, 16'h0000, 0, 1, 1, EV_ADDED, 0, 1, 0, 1);
        // Elapsed beyond every remaining time: the whole bank expires at once.
        plan_row(KIND_TICK, 0, 16'h0000, 2);
        // Two long durations, then two equal ones to exercise the tie rule.
        plan_row(KIND_ADD, 86399999, 16'h0000, 0, 1, 1, EV_ADDED, 0, 1, 0, 86399999);
        plan_row(KIND_ADD, 67108863, 16'h0000, 0, 1, 1, EV_ADDED, 1, 1, 1, 67108863);
        plan_row(KIND_ADD, 100, 16'h0000, 0, 1, 1, EV_ADDED, 2, 1, 2, 100);
        plan_row(KIND_ADD, 100, 16'h0000, 0, 1, 1, EV_ADDED, 3, 1, 2, 100);
        plan_row(KIND_PAUSE, 0, 16'h0004, 0, 1, 1, EV_SEL_DONE, 0, 1, 2, 100);
        // Elapsed equal to remaining reaches zero, and expires on the next tick.
        plan_row(KIND_TICK, 0, 16'h0000, 100);
        plan_row(KIND_TICK, 0, 16'h0000, 0);
        plan_row(KIND_TICK, 0, 16'h0000, 16'hFFFF);
        plan_row(KIND_CONT, 0, 16'hFFFF, 0);
        plan_row(KIND_TICK, 0, 16'h0000, 16'hFFFF);
        plan_row(KIND_PAUSE, 0, 16'hFFFF, 0);
        plan_row(KIND_CONT, 0, 16'h0000, 0);
        plan_row(KIND_CONT, 0, 16'hFFFF, 0);

        foreach (plan[n]) begin
            for (int k = 0; k < plan[n].reps; k++) begin
                send_cmd(plan[n].cmd, pick_gap());
                apply_item(plan[n].cmd, plan[n].typed, plan[n].want);
            end
        end
        drain_results();

        // Random part. Durations and elapsed times are kept mostly small so
        // that slots keep filling and expiring; the two long timers loaded
        // above stay in the bank throughout.
        for (int n = 0; n < 330; n++) begin
            steady = (n >= 120 && n < 170);
            if (n % 60 == 59) begin
                drain_results();
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                c.kind = KIND_ADD;
            end else if (r < 75) begin
                c.kind = KIND_TICK;
            end else if (r < 87) begin
                c.kind = KIND_PAUSE;
            end else begin
                c.kind = KIND_CONT;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                c.dur = '0;
            end else if (r < 85) begin
                c.dur = t_dur'($urandom_range(1, 400));
            end else begin
                c.dur = t_dur'($urandom_range(401, 30000));
            end
            c.mask = MASK_W'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 10) begin
                c.elapsed = '0;
            end else if (r < 80) begin
                c.elapsed = ELAP_W'($urandom_range(1, 60));
            end else if (r < 95) begin
                c.elapsed = ELAP_W'($urandom_range(61, 600));
            end else begin
                c.elapsed = ELAP_W'($urandom_range(601, 65535));
            end
            send_cmd(c, pick_gap());
            apply_item(c, 1'b0, '0);
        end
        steady = 1'b0;
        drain_results();
        repeat (SLOTS + 8) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
